/* hdl/cfpr_pkg.sv */
`timescale 1ns / 1ps

package cfpr_pkg;

  localparam int unsigned BufferBytesDefault = 256;

  localparam logic [7:0] HdrFirst  = 8'h5A;
  localparam logic [7:0] HdrSecond = 8'hA5;
  localparam logic [7:0] MinLen    = 8'd5;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  typedef enum logic [2:0] {
    PhWaitFirst,
    PhWaitSecond,
    PhLength,
    PhBody,
    PhCrcLow,
    PhCrcHigh
  } phase_e;

  typedef enum logic [1:0] {
    KindPayload,
    KindGood,
    KindBad,
    KindLenErr
  } kind_e;

  typedef struct packed {
    kind_e       out_kind;
    logic [7:0]  payload_data;
    logic [15:0] frame_ident;
    logic [7:0]  payload_count;
  } result_t;

  // One byte of the reflected CRC-16/MODBUS, eight shift steps unrolled.
  function automatic logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* hdl/cfpr_in_if.sv */
`timescale 1ns / 1ps

interface cfpr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_data;

  modport source (output valid, output rx_data, input ready);
  modport sink (input valid, input rx_data, output ready);
endinterface

/* hdl/cfpr_out_if.sv */
`timescale 1ns / 1ps

interface cfpr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_kind;
  logic [7:0]  payload_data;
  logic [15:0] frame_ident;
  logic [7:0]  payload_count;

  modport source (output valid, output out_kind, output payload_data, output frame_ident,
                  output payload_count, input ready);
  modport sink (input valid, input out_kind, input payload_data, input frame_ident,
                input payload_count, output ready);
endinterface

/* hdl/crc_framed_packet_receiver.sv */
`timescale 1ns / 1ps

// Framed packet receiver. Serial bytes enter on rx_i, one request per byte. The
// block hunts for the header 0x5A 0xA5, takes a length byte and the body, and
// checks a CRC-16/MODBUS sent low byte first. Each payload byte leaves on res_o
// as it arrives (kind payload) together with the frame ID and payload count; the
// last CRC byte yields a frame end marked good or bad, and the consumer drops the
// payload of a frame marked bad. A length below 5 or too large for the buffer
// gives one length error request and hunting resumes.
// A byte accepted is held in the input register, and its result is loaded into the
// output register, or into the skid register while the output register is held.
// Throughput: one byte per cycle while the skid register is free, set by the
// combinational byte-wide CRC update and state step between the input register
// and the output register. The output side has a main register and a skid register,
// so input keeps flowing while one result waits; input stalls only when the skid
// register and the input register are both full. Reset clears the hunt state, the
// CRC to 0xFFFF and all valid flags; the block is ready for a byte once reset is released.
module crc_framed_packet_receiver #(
  parameter int unsigned BUFFER_BYTES = cfpr_pkg::BufferBytesDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  cfpr_in_if.sink       rx_i,
  cfpr_out_if.source    res_o
);

  localparam int unsigned MaxLen = BUFFER_BYTES - 3;

  logic        in_valid_q, in_valid_d;
  logic [7:0]  in_data_q;
  logic        advance;
  logic        accept;

  cfpr_pkg::phase_e phase_q, phase_d;
  logic [7:0]  length_q, length_d;
  logic [7:0]  pos_q, pos_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] ident_q, ident_d;
  logic [7:0]  crc_low_q, crc_low_d;

  logic             bad_len;
  logic [7:0]       pos_inc;
  logic [7:0]       count;
  logic             res_valid;
  cfpr_pkg::result_t res;

  logic              out_valid_q;
  cfpr_pkg::result_t out_q;
  logic              skid_valid_q;
  cfpr_pkg::result_t skid_q;
  logic              take;

  assign rx_i.ready = !(in_valid_q && skid_valid_q);
  assign accept     = rx_i.valid && rx_i.ready;
  assign advance    = in_valid_q && !skid_valid_q;

  assign in_valid_d = accept ? 1'b1 : (advance ? 1'b0 : in_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_data_q <= rx_i.rx_data;
    end
  end

  assign bad_len = (in_data_q < cfpr_pkg::MinLen) || (32'(in_data_q) > MaxLen);
  assign pos_inc = pos_q + 8'd1;
  assign count   = length_q - cfpr_pkg::MinLen;

  // Next state of the hunt and frame tracking.
  always_comb begin
    phase_d   = phase_q;
    length_d  = length_q;
    pos_d     = pos_q;
    crc_d     = crc_q;
    ident_d   = ident_q;
    crc_low_d = crc_low_q;
    if (advance) begin
      unique case (phase_q)
        cfpr_pkg::PhWaitSecond: begin
          if (in_data_q == cfpr_pkg::HdrSecond) begin
            phase_d = cfpr_pkg::PhLength;
          end else if (in_data_q != cfpr_pkg::HdrFirst) begin
            phase_d = cfpr_pkg::PhWaitFirst;
          end
        end
        cfpr_pkg::PhLength: begin
          if (bad_len) begin
            // A rejected length byte may itself start the next header.
            phase_d = (in_data_q == cfpr_pkg::HdrFirst) ? cfpr_pkg::PhWaitSecond
                                                        : cfpr_pkg::PhWaitFirst;
          end else begin
            length_d = in_data_q;
            pos_d    = 8'd0;
            crc_d    = cfpr_pkg::CrcInit;
            ident_d  = 16'h0000;
            phase_d  = cfpr_pkg::PhBody;
          end
        end
        cfpr_pkg::PhBody: begin
          crc_d = cfpr_pkg::crc16_update(crc_q, in_data_q);
          pos_d = pos_inc;
          if (pos_inc >= length_q - 8'd2) begin
            phase_d = cfpr_pkg::PhCrcLow;
          end
          if (pos_q == 8'd1) begin
            ident_d = {8'h00, in_data_q};
          end else if (pos_q == 8'd2) begin
            ident_d = ident_q | {in_data_q, 8'h00};
          end
        end
        cfpr_pkg::PhCrcLow: begin
          crc_low_d = in_data_q;
          phase_d   = cfpr_pkg::PhCrcHigh;
        end
        cfpr_pkg::PhCrcHigh: begin
          phase_d = cfpr_pkg::PhWaitFirst;
        end
        default: begin
          phase_d = (in_data_q == cfpr_pkg::HdrFirst) ? cfpr_pkg::PhWaitSecond
                                                      : cfpr_pkg::PhWaitFirst;
        end
      endcase
    end
  end

  // Result produced by the byte in the input register.
  always_comb begin
    res_valid         = 1'b0;
    res.out_kind      = cfpr_pkg::KindPayload;
    res.payload_data  = 8'h00;
    res.frame_ident   = 16'h0000;
    res.payload_count = 8'h00;
    if (advance) begin
      unique case (phase_q)
        cfpr_pkg::PhLength: begin
          if (bad_len) begin
            res_valid    = 1'b1;
            res.out_kind = cfpr_pkg::KindLenErr;
          end
        end
        cfpr_pkg::PhBody: begin
          if (pos_q >= 8'd3) begin
            res_valid         = 1'b1;
            res.payload_data  = in_data_q;
            res.frame_ident   = ident_q;
            res.payload_count = count;
          end
        end
        cfpr_pkg::PhCrcHigh: begin
          res_valid         = 1'b1;
          res.out_kind      = ({in_data_q, crc_low_q} == crc_q) ? cfpr_pkg::KindGood
                                                                 : cfpr_pkg::KindBad;
          res.frame_ident   = ident_q;
          res.payload_count = count;
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= cfpr_pkg::PhWaitFirst;
      length_q  <= 8'd0;
      pos_q     <= 8'd0;
      crc_q     <= cfpr_pkg::CrcInit;
      ident_q   <= 16'h0000;
      crc_low_q <= 8'd0;
    end else begin
      phase_q   <= phase_d;
      length_q  <= length_d;
      pos_q     <= pos_d;
      crc_q     <= crc_d;
      ident_q   <= ident_d;
      crc_low_q <= crc_low_d;
    end
  end

  // Output register with a skid register behind it. A new result never meets a
  // full skid register, because the input register only advances when it is empty.
  assign take = out_valid_q && res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (take || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take || !out_valid_q) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (res_valid) begin
        out_q <= res;
      end
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.out_kind      = out_q.out_kind;
  assign res_o.payload_data  = out_q.payload_data;
  assign res_o.frame_ident   = out_q.frame_ident;
  assign res_o.payload_count = out_q.payload_count;

  a_skid_behind_main : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a result while the output register is empty");

  a_body_bounds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == cfpr_pkg::PhBody) |->
      (length_q >= cfpr_pkg::MinLen) && (pos_q < length_q - 8'd2))
    else $error("body position out of range for the frame length");

  a_crc_position : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((phase_q == cfpr_pkg::PhCrcLow) || (phase_q == cfpr_pkg::PhCrcHigh)) |->
      (pos_q == length_q - 8'd2))
    else $error("CRC bytes reached at the wrong body position");

  a_frame_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (phase_q == cfpr_pkg::PhCrcHigh)) |=> (phase_q == cfpr_pkg::PhWaitFirst))
    else $error("hunting did not resume after a frame end");

  a_stall_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && skid_valid_q) |=> $stable(in_data_q))
    else $error("input register changed while the output side was full");

endmodule
